// ----- rtl/lups_pkg.sv -----
// Shared types, constants and codes for the LU pivot linear solver.
`default_nettype none
package lups_pkg;
    localparam int MAX_DIM = 8;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int SIZE_W = 4;
    localparam int DATA_W = 32;
    localparam int QDIV_W = DATA_W + FRAC_BITS;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic start;
        word_t num;
        word_t den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        word_t quo;
    } div_rsp_t;

    function automatic word_t sat64(input logic signed [63:0] v);
        if (v > 64'(SAT_MAX)) return SAT_MAX;
        if (v < 64'(SAT_MIN)) return SAT_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic word_t qsub(input word_t a, input word_t b);
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1]) return d[DATA_W] ? SAT_MIN : SAT_MAX;
        return d[DATA_W-1:0];
    endfunction

    function automatic word_t qround(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return sat64(r);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/lups_if.sv -----
// Valid/ready channel interfaces for load, result and configuration beats.
`default_nettype none
interface lups_load_if;
    logic valid;
    logic ready;
    logic [lups_pkg::IDX_W-1:0] row_index;
    logic [lups_pkg::IDX_W-1:0] col_index;
    logic is_rhs;
    logic signed [31:0] element_value;
    logic load_done;
    modport source(output valid, row_index, col_index, is_rhs, element_value, load_done,
                   input ready);
    modport sink(input valid, row_index, col_index, is_rhs, element_value, load_done,
                 output ready);
endinterface

interface lups_result_if;
    logic valid;
    logic ready;
    logic [lups_pkg::IDX_W-1:0] solution_index;
    logic signed [31:0] solution_value;
    logic singular;
    logic last_result;
    modport source(output valid, solution_index, solution_value, singular, last_result,
                   input ready);
    modport sink(input valid, solution_index, solution_value, singular, last_result,
                 output ready);
endinterface

interface lups_cfg_if;
    logic valid;
    logic ready;
    logic [3:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lups_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module lups_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/lups_div.sv -----
// Serial restoring divider for saturated Q-format quotients.
`default_nettype none
module lups_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire lups_pkg::div_req_t req,
    output lups_pkg::div_rsp_t rsp
);
    localparam int W = lups_pkg::QDIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] quo_reg;
    logic [W:0] rem_reg;
    logic [W-1:0] dvs_reg;
    logic neg_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [W:0] trial;
    logic [W:0] shifted;
    logic signed [W:0] sq;
    logic [W-1:0] na;
    logic [W-1:0] nb;

    always_comb
    begin
        na = req.num[lups_pkg::DATA_W-1] ? W'(-{{(W-lups_pkg::DATA_W){req.num[31]}}, req.num})
                                         : W'({{(W-lups_pkg::DATA_W){1'b0}}, req.num});
        nb = req.den[lups_pkg::DATA_W-1] ? W'(-{{(W-lups_pkg::DATA_W){req.den[31]}}, req.den})
                                         : W'({{(W-lups_pkg::DATA_W){1'b0}}, req.den});
        shifted = {rem_reg[W-1:0], quo_reg[W-1]};
        trial = shifted - {1'b0, dvs_reg};
        sq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(W);
                quo_reg <= na << lups_pkg::FRAC_BITS;
                rem_reg <= '0;
                dvs_reg <= nb;
                neg_reg <= req.num[31] ^ req.den[31];
            end
            else if (busy_reg)
            begin
                if (trial[W])
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo = lups_pkg::sat64(64'(sq));
endmodule
`default_nettype wire

// ----- rtl/lu_pivot_linear_solver.sv -----
// Top level of the LU pivot linear solver.
// Load beats are taken one per cycle; a beat with load_done starts the solve and the block
// drops ready until all N result beats are taken. The solve runs on one shared multiply,
// subtract and compare datapath plus a 48-step serial divider under a sequencer, over a
// single-read matrix RAM. No clearing pass.
`default_nettype none
module lu_pivot_linear_solver (
    input  wire logic clk,
    input  wire logic rst_n,
    lups_load_if.sink load,
    lups_result_if.source result,
    lups_cfg_if.sink cfg
);
    localparam int IW = lups_pkg::IDX_W;
    localparam int AW = lups_pkg::ADDR_W;

    localparam logic [4:0] S_LOAD = 5'd0;
    localparam logic [4:0] S_PV_RD = 5'd1;
    localparam logic [4:0] S_PV_CMP = 5'd2;
    localparam logic [4:0] S_SW_RDA = 5'd3;
    localparam logic [4:0] S_SW_RDB = 5'd4;
    localparam logic [4:0] S_SW_WRA = 5'd5;
    localparam logic [4:0] S_EL_PIV = 5'd6;
    localparam logic [4:0] S_EL_CHK = 5'd7;
    localparam logic [4:0] S_EL_RDI = 5'd8;
    localparam logic [4:0] S_EL_DIV = 5'd9;
    localparam logic [4:0] S_EL_RDK = 5'd10;
    localparam logic [4:0] S_EL_RDJ = 5'd11;
    localparam logic [4:0] S_EL_UPD = 5'd12;
    localparam logic [4:0] S_FW_RD = 5'd13;
    localparam logic [4:0] S_FW_MAC = 5'd14;
    localparam logic [4:0] S_BK_RD = 5'd15;
    localparam logic [4:0] S_BK_MAC = 5'd16;
    localparam logic [4:0] S_BK_DIA = 5'd17;
    localparam logic [4:0] S_BK_DIV = 5'd18;
    localparam logic [4:0] S_OUT = 5'd19;
    localparam logic [4:0] S_SW_WRB = 5'd21;
    localparam logic [4:0] S_MUL = 5'd22;

    logic [4:0] state_reg;
    logic [4:0] ret_reg;
    logic [lups_pkg::SIZE_W-1:0] size_reg;
    logic [IW:0] n_reg;
    logic [IW:0] i_reg;
    logic [IW:0] j_reg;
    logic [IW:0] k_reg;
    logic [IW:0] best_reg;
    logic [lups_pkg::DATA_W:0] bm_reg;
    logic [IW-1:0] order_reg [lups_pkg::MAX_DIM];
    lups_pkg::word_t rhs_reg [lups_pkg::MAX_DIM];
    lups_pkg::word_t y_reg [lups_pkg::MAX_DIM];
    lups_pkg::word_t x_reg [lups_pkg::MAX_DIM];
    lups_pkg::word_t a_reg;
    lups_pkg::word_t b_reg;
    lups_pkg::word_t acc_reg;
    lups_pkg::word_t piv_reg;
    logic signed [63:0] prod_reg;
    logic sing_reg;
    logic [IW:0] oi_reg;
    logic rd_wait_reg;

    logic we;
    logic [AW-1:0] waddr;
    lups_pkg::word_t wdata;
    logic [AW-1:0] raddr;
    logic [lups_pkg::DATA_W-1:0] rdata;
    lups_pkg::div_req_t dreq;
    lups_pkg::div_rsp_t drsp;
    logic load_fire;
    logic [lups_pkg::DATA_W:0] rmag;
    lups_pkg::word_t rq;
    logic [IW:0] nsize;

    lups_ram #(.WIDTH(lups_pkg::DATA_W), .DEPTH(lups_pkg::DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    lups_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic [AW-1:0] adr(input logic [IW:0] r, input logic [IW:0] c);
        return {r[IW-1:0], c[IW-1:0]};
    endfunction

    assign load_fire = load.valid && load.ready;
    assign load.ready = (state_reg == S_LOAD);
    assign cfg.ready = 1'b1;
    assign rq = $signed(rdata);
    assign rmag = rq[31] ? -{rq[31], rq} : {1'b0, rq};
    assign nsize = (size_reg == '0) ? (IW+1)'(1)
                 : (size_reg > lups_pkg::SIZE_W'(lups_pkg::MAX_DIM))
                 ? (IW+1)'(lups_pkg::MAX_DIM) : size_reg[IW:0];

    assign result.valid = (state_reg == S_OUT);
    assign result.solution_index = oi_reg[IW-1:0];
    assign result.solution_value = sing_reg ? '0 : x_reg[oi_reg[IW-1:0]];
    assign result.singular = sing_reg;
    assign result.last_result = (oi_reg == n_reg - 1'b1);

    always_comb
    begin
        we = 1'b0;
        waddr = adr(i_reg, j_reg);
        wdata = acc_reg;
        raddr = adr(i_reg, j_reg);
        dreq.start = 1'b0;
        dreq.num = acc_reg;
        dreq.den = piv_reg;
        case (state_reg)
            S_LOAD:
            begin
                we = load_fire && !load.is_rhs;
                waddr = {load.row_index, load.col_index};
                wdata = load.element_value;
            end
            S_PV_RD: raddr = adr(j_reg, i_reg);
            S_SW_RDA: raddr = adr(i_reg, j_reg);
            S_SW_RDB: raddr = adr(best_reg, j_reg);
            S_SW_WRA:
            begin
                raddr = adr(best_reg, j_reg);
                we = !rd_wait_reg;
                waddr = adr(i_reg, j_reg);
                wdata = rq;
            end
            S_SW_WRB:
            begin
                we = 1'b1;
                waddr = adr(best_reg, j_reg);
                wdata = a_reg;
            end
            S_EL_PIV, S_EL_CHK: raddr = adr(k_reg, k_reg);
            S_EL_RDI: raddr = adr(i_reg, k_reg);
            S_EL_DIV:
            begin
                raddr = adr(i_reg, k_reg);
                dreq.start = !rd_wait_reg && !drsp.busy && !drsp.done
                           && ret_reg == S_EL_RDI;
                dreq.num = rq;
                we = drsp.done;
                waddr = adr(i_reg, k_reg);
                wdata = drsp.quo;
            end
            S_EL_RDK: raddr = adr(k_reg, j_reg);
            S_EL_RDJ: raddr = adr(k_reg, j_reg);
            S_EL_UPD:
            begin
                we = 1'b1;
                waddr = adr(i_reg, j_reg);
                wdata = lups_pkg::qsub(rq, lups_pkg::qround(prod_reg));
            end
            S_FW_RD: raddr = adr(i_reg, j_reg);
            S_BK_RD: raddr = adr(i_reg, j_reg);
            S_BK_DIA: raddr = adr(i_reg, i_reg);
            S_BK_DIV:
            begin
                raddr = adr(i_reg, i_reg);
                dreq.start = (ret_reg == S_BK_DIA);
                dreq.num = acc_reg;
                dreq.den = rq;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ret_reg <= S_LOAD;
            size_reg <= lups_pkg::SIZE_RESET;
            rd_wait_reg <= 1'b0;
            sing_reg <= 1'b0;
            for (int q = 0; q < lups_pkg::MAX_DIM; q++)
            begin
                order_reg[q] <= IW'(q);
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                size_reg <= cfg.data;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (load_fire)
                    begin
                        if (load.is_rhs)
                        begin
                            rhs_reg[load.row_index] <= load.element_value;
                        end
                        if (load.load_done)
                        begin
                            n_reg <= nsize;
                            for (int q = 0; q < lups_pkg::MAX_DIM; q++)
                            begin
                                order_reg[q] <= IW'(q);
                            end
                            i_reg <= '0;
                            j_reg <= '0;
                            best_reg <= '0;
                            bm_reg <= '0;
                            sing_reg <= 1'b0;
                            rd_wait_reg <= 1'b1;
                            state_reg <= S_PV_RD;
                        end
                    end
                end
                S_PV_RD:
                begin
                    rd_wait_reg <= 1'b0;
                    state_reg <= S_PV_CMP;
                end
                S_PV_CMP:
                begin
                    if (j_reg == i_reg || rmag > bm_reg)
                    begin
                        bm_reg <= rmag;
                        best_reg <= j_reg;
                    end
                    if (j_reg + 1'b1 < n_reg)
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_PV_RD;
                    end
                    else
                    begin
                        j_reg <= '0;
                        state_reg <= S_SW_RDA;
                    end
                end
                S_SW_RDA:
                begin
                    if (best_reg == i_reg)
                    begin
                        if (i_reg + 1'b1 < n_reg)
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + 1'b1;
                            state_reg <= S_PV_RD;
                        end
                        else
                        begin
                            k_reg <= '0;
                            state_reg <= S_EL_PIV;
                        end
                    end
                    else
                    begin
                        if (j_reg == '0)
                        begin
                            order_reg[i_reg[IW-1:0]] <= order_reg[best_reg[IW-1:0]];
                            order_reg[best_reg[IW-1:0]] <= order_reg[i_reg[IW-1:0]];
                        end
                        state_reg <= S_SW_RDB;
                    end
                end
                S_SW_RDB:
                begin
                    a_reg <= rq;
                    rd_wait_reg <= 1'b1;
                    state_reg <= S_SW_WRA;
                end
                S_SW_WRA:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_SW_WRB;
                    end
                end
                S_SW_WRB:
                begin
                    if (j_reg + 1'b1 < (IW+1)'(lups_pkg::MAX_DIM))
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_SW_RDA;
                    end
                    else
                    begin
                        best_reg <= i_reg;
                        j_reg <= '0;
                        state_reg <= S_SW_RDA;
                    end
                end
                S_EL_PIV: state_reg <= S_EL_CHK;
                S_EL_CHK:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_wait_reg <= 1'b1;
                        if (rq == '0)
                        begin
                            sing_reg <= 1'b1;
                            oi_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            piv_reg <= rq;
                            i_reg <= k_reg + 1'b1;
                            state_reg <= (k_reg + 1'b1 < n_reg) ? S_EL_RDI : S_FW_RD;
                            if (k_reg + 1'b1 >= n_reg)
                            begin
                                i_reg <= '0;
                                j_reg <= '0;
                                acc_reg <= rhs_reg[order_reg[0]];
                            end
                        end
                    end
                end
                S_EL_RDI:
                begin
                    ret_reg <= S_EL_RDI;
                    rd_wait_reg <= 1'b1;
                    state_reg <= S_EL_DIV;
                end
                S_EL_DIV:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else if (ret_reg == S_EL_RDI)
                    begin
                        ret_reg <= S_EL_DIV;
                    end
                    else if (drsp.done)
                    begin
                        b_reg <= drsp.quo;
                        j_reg <= k_reg + 1'b1;
                        state_reg <= (k_reg + 1'b1 < n_reg) ? S_EL_RDK : S_EL_PIV;
                    end
                end
                S_EL_RDK:
                begin
                    rd_wait_reg <= 1'b1;
                    state_reg <= S_EL_RDJ;
                end
                S_EL_RDJ:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        prod_reg <= 64'(rq) * 64'(b_reg);
                        rd_wait_reg <= 1'b1;
                        state_reg <= S_MUL;
                        ret_reg <= S_EL_UPD;
                    end
                end
                S_MUL:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_EL_UPD:
                begin
                    if (j_reg + 1'b1 < n_reg)
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_EL_RDK;
                    end
                    else if (i_reg + 1'b1 < n_reg)
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_EL_RDI;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        rd_wait_reg <= 1'b1;
                        state_reg <= S_EL_PIV;
                    end
                end
                S_FW_RD:
                begin
                    if (j_reg >= i_reg)
                    begin
                        y_reg[i_reg[IW-1:0]] <= acc_reg;
                        if (i_reg + 1'b1 < n_reg)
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= '0;
                            acc_reg <= rhs_reg[order_reg[i_reg[IW-1:0] + 1'b1]];
                        end
                        else
                        begin
                            i_reg <= n_reg - 1'b1;
                            j_reg <= n_reg;
                            state_reg <= S_BK_RD;
                        end
                    end
                    else
                    begin
                        rd_wait_reg <= 1'b1;
                        state_reg <= S_FW_MAC;
                    end
                end
                S_FW_MAC:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                        prod_reg <= 64'sd0;
                    end
                    else if (prod_reg == 64'sd0 && ret_reg != S_FW_MAC)
                    begin
                        prod_reg <= 64'(rq) * 64'(y_reg[j_reg[IW-1:0]]);
                        ret_reg <= S_FW_MAC;
                    end
                    else
                    begin
                        acc_reg <= lups_pkg::qsub(acc_reg, lups_pkg::qround(prod_reg));
                        ret_reg <= S_FW_RD;
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_FW_RD;
                    end
                end
                S_BK_RD:
                begin
                    if (j_reg >= n_reg)
                    begin
                        ret_reg <= S_BK_RD;
                        state_reg <= S_BK_DIA;
                    end
                    else
                    begin
                        rd_wait_reg <= 1'b1;
                        state_reg <= S_BK_MAC;
                    end
                end
                S_BK_MAC:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                        ret_reg <= S_BK_RD;
                    end
                    else if (ret_reg == S_BK_RD)
                    begin
                        prod_reg <= 64'(rq) * 64'(x_reg[j_reg[IW-1:0]]);
                        ret_reg <= S_BK_MAC;
                    end
                    else
                    begin
                        acc_reg <= lups_pkg::qsub(acc_reg, lups_pkg::qround(prod_reg));
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_BK_RD;
                    end
                end
                S_BK_DIA:
                begin
                    rd_wait_reg <= 1'b1;
                    ret_reg <= S_BK_RD;
                    state_reg <= S_BK_DIV;
                end
                S_BK_DIV:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else if (ret_reg == S_BK_RD)
                    begin
                        if (rq == '0)
                        begin
                            sing_reg <= 1'b1;
                            oi_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ret_reg <= S_BK_DIA;
                        end
                    end
                    else if (ret_reg == S_BK_DIA)
                    begin
                        ret_reg <= S_BK_DIV;
                    end
                    else if (drsp.done)
                    begin
                        x_reg[i_reg[IW-1:0]] <= drsp.quo;
                        if (i_reg == '0)
                        begin
                            oi_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            i_reg <= i_reg - 1'b1;
                            j_reg <= i_reg;
                            acc_reg <= y_reg[i_reg[IW-1:0] - 1'b1];
                            state_reg <= S_BK_RD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (result.ready)
                    begin
                        if (oi_reg == n_reg - 1'b1)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            oi_reg <= oi_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    a_ready_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        load.ready |-> !result.valid) else $error("load ready while results pending");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && result.last_result |=> load.ready)
        else $error("no return to load after last beat");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !drsp.busy) else $error("divider restarted while busy");
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.singular |-> result.solution_value == '0)
        else $error("singular beat with nonzero value");
endmodule
`default_nettype wire

// ----- tb/tb_lu_pivot_linear_solver.sv -----
// Self-checking testbench for the LU pivot linear solver: random and directed solves.
`timescale 1ns / 1ps
module tb_lu_pivot_linear_solver;
    typedef struct {
        lups_pkg::idx_t index;
        lups_pkg::word_t value;
        logic singular;
        logic last;
    } soln_t;

    typedef struct {
        lups_pkg::idx_t r;
        lups_pkg::idx_t c;
        logic rhs;
    } slot_t;

    class lu_solve_scoreboard;
        lups_pkg::word_t fac[lups_pkg::MAX_DIM][lups_pkg::MAX_DIM];
        lups_pkg::word_t rhs_vec[lups_pkg::MAX_DIM];
        lups_pkg::idx_t order[lups_pkg::MAX_DIM];
        lups_pkg::word_t yv[lups_pkg::MAX_DIM];
        logic [lups_pkg::SIZE_W-1:0] size;
        soln_t pending_q[$];
        int errors;

        function new();
            size = lups_pkg::SIZE_RESET;
            errors = 0;
            for (int i = 0; i < lups_pkg::MAX_DIM; i++) order[i] = lups_pkg::idx_t'(i);
        endfunction

        function lups_pkg::word_t clamp(logic signed [63:0] v);
            if (v > 64'sh7fffffff) return lups_pkg::SAT_MAX;
            if (v < -64'sh80000000) return lups_pkg::SAT_MIN;
            return v[31:0];
        endfunction

        function lups_pkg::word_t fx_mul(lups_pkg::word_t a, lups_pkg::word_t b);
            logic signed [63:0] p;
            p = 64'(a) * 64'(b) + (64'sd1 <<< (lups_pkg::FRAC_BITS - 1));
            return clamp(p >>> lups_pkg::FRAC_BITS);
        endfunction

        function lups_pkg::word_t fx_sub(lups_pkg::word_t a, lups_pkg::word_t b);
            return clamp(64'(a) - 64'(b));
        endfunction

        function lups_pkg::word_t fx_div(lups_pkg::word_t a, lups_pkg::word_t b);
            logic signed [63:0] num;
            num = 64'(a) <<< lups_pkg::FRAC_BITS;
            return clamp(num / 64'(b));
        endfunction

        function logic signed [63:0] magn(lups_pkg::word_t v);
            return v < 0 ? -64'(v) : 64'(v);
        endfunction

        function bit run_solve(int n, output lups_pkg::word_t x[lups_pkg::MAX_DIM]);
            int best;
            logic signed [63:0] bm;
            lups_pkg::idx_t t;
            lups_pkg::word_t w, piv, f, acc;
            for (int i = 0; i < lups_pkg::MAX_DIM; i++)
            begin
                order[i] = lups_pkg::idx_t'(i);
                x[i] = '0;
            end
            for (int i = 0; i < n; i++)
            begin
                best = i;
                bm = magn(fac[i][i]);
                for (int j = i; j < n; j++)
                    if (magn(fac[j][i]) > bm)
                    begin
                        best = j;
                        bm = magn(fac[j][i]);
                    end
                if (best != i)
                begin
                    t = order[i];
                    order[i] = order[best];
                    order[best] = t;
                    for (int k = 0; k < lups_pkg::MAX_DIM; k++)
                    begin
                        w = fac[i][k];
                        fac[i][k] = fac[best][k];
                        fac[best][k] = w;
                    end
                end
            end
            for (int k = 0; k < n; k++)
            begin
                piv = fac[k][k];
                if (piv == 0) return 1;
                for (int i = k + 1; i < n; i++)
                begin
                    f = fx_div(fac[i][k], piv);
                    fac[i][k] = f;
                    for (int j = k + 1; j < n; j++)
                        fac[i][j] = fx_sub(fac[i][j], fx_mul(fac[k][j], f));
                end
            end
            for (int i = 0; i < n; i++)
            begin
                acc = rhs_vec[order[i]];
                for (int j = 0; j < i; j++) acc = fx_sub(acc, fx_mul(fac[i][j], yv[j]));
                yv[i] = acc;
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                acc = yv[i];
                for (int j = i + 1; j < n; j++) acc = fx_sub(acc, fx_mul(fac[i][j], x[j]));
                if (fac[i][i] == 0) return 1;
                x[i] = fx_div(acc, fac[i][i]);
            end
            return 0;
        endfunction

        function void note_size(logic [lups_pkg::SIZE_W-1:0] v);
            size = v;
        endfunction

        function void note_load(lups_pkg::idx_t r, lups_pkg::idx_t c, logic is_b,
                                lups_pkg::word_t v, logic done);
            int n;
            bit sing;
            lups_pkg::word_t x[lups_pkg::MAX_DIM];
            soln_t s;
            if (is_b) rhs_vec[r] = v;
            else fac[r][c] = v;
            if (!done) return;
            n = size;
            if (n < 1) n = 1;
            if (n > lups_pkg::MAX_DIM) n = lups_pkg::MAX_DIM;
            sing = run_solve(n, x);
            for (int i = 0; i < n; i++)
            begin
                s.index = lups_pkg::idx_t'(i);
                s.value = sing ? '0 : x[i];
                s.singular = sing;
                s.last = (i == n - 1);
                pending_q.push_back(s);
            end
        endfunction

        function void check(lups_pkg::idx_t si, lups_pkg::word_t sv, logic sg, logic lr);
            soln_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result index %0d value %h", $time, si, sv);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (si !== e.index)
            begin
                $display("%0t: solution_index expected %0d actual %0d", $time, e.index, si);
                errors++;
            end
            if (sv !== e.value)
            begin
                $display("%0t: solution_value expected %h actual %h", $time, e.value, sv);
                errors++;
            end
            if (sg !== e.singular)
            begin
                $display("%0t: singular expected %b actual %b", $time, e.singular, sg);
                errors++;
            end
            if (lr !== e.last)
            begin
                $display("%0t: last_result expected %b actual %b", $time, e.last, lr);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    lups_load_if load ();
    lups_result_if result ();
    lups_cfg_if cfg ();

    lu_pivot_linear_solver dut (
        .clk(clk),
        .rst_n(rst_n),
        .load(load.sink),
        .result(result.source),
        .cfg(cfg.sink)
    );

    lu_solve_scoreboard sb = new();
    int items_sent = 0;
    int burst_left = 0;
    bit long_hold = 0;
    bit hold_used = 0;

    always #5 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && load.valid && load.ready)
            sb.note_load(load.row_index, load.col_index, load.is_rhs, load.element_value,
                         load.load_done);
        if (rst_n && result.valid && result.ready)
            sb.check(result.solution_index, result.solution_value, result.singular,
                     result.last_result);
        if (rst_n && cfg.valid && cfg.ready)
            sb.note_size(cfg.data);
    end

    initial
    begin
        int mode;
        int span;
        result.ready = 0;
        mode = 0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result.ready <= 0;
                repeat (5000) @(posedge clk);
                long_hold = 0;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 80);
            end
            span--;
            case (mode)
                0: result.ready <= 1;
                1: result.ready <= 1'($urandom_range(0, 1));
                default: result.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_elem(lups_pkg::idx_t r, lups_pkg::idx_t c, logic is_b,
                             lups_pkg::word_t v, logic done);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                load.valid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        load.valid <= 1;
        load.row_index <= r;
        load.col_index <= c;
        load.is_rhs <= is_b;
        load.element_value <= v;
        load.load_done <= done;
        @(posedge clk);
        while (!load.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_size(logic [lups_pkg::SIZE_W-1:0] v);
        load.valid <= 0;
        burst_left = 0;
        drain();
        cfg.valid <= 1;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    function automatic lups_pkg::word_t pick_value(bit tidy, slot_t s);
        lups_pkg::word_t v;
        if (!tidy) return $urandom;
        if (s.rhs) v = lups_pkg::word_t'($urandom_range(0, 8 << 16));
        else if (s.r == s.c) v = lups_pkg::word_t'($urandom_range(2 << 16, 8 << 16));
        else v = lups_pkg::word_t'($urandom_range(0, 1 << 16));
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic load_set(int n, bit tidy, int extra);
        slot_t q[$];
        slot_t s;
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                s.r = lups_pkg::idx_t'(r);
                s.c = lups_pkg::idx_t'(c);
                s.rhs = 0;
                q.push_back(s);
            end
            s.r = lups_pkg::idx_t'(r);
            s.c = lups_pkg::idx_t'($urandom);
            s.rhs = 1;
            q.push_back(s);
        end
        for (int i = 0; i < extra; i++)
        begin
            s.r = lups_pkg::idx_t'($urandom);
            s.c = lups_pkg::idx_t'($urandom);
            s.rhs = 1'($urandom_range(0, 1));
            q.push_back(s);
        end
        q.shuffle();
        for (int i = 0; i < q.size(); i++)
            send_elem(q[i].r, q[i].c, q[i].rhs, pick_value(tidy, q[i]), i == q.size() - 1);
    endtask

    initial
    begin
        int n;
        int cfg_val;
        load.valid = 0;
        load.row_index = '0;
        load.col_index = '0;
        load.is_rhs = 0;
        load.element_value = '0;
        load.load_done = 0;
        cfg.valid = 0;
        cfg.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        load_set(lups_pkg::MAX_DIM, 1, 0);

        write_size(4'd1);
        send_elem(0, 0, 0, lups_pkg::SAT_MAX, 0);
        send_elem(0, 7, 1, lups_pkg::SAT_MIN, 1);
        send_elem(0, 0, 0, lups_pkg::SAT_MIN, 0);
        send_elem(0, 0, 1, lups_pkg::SAT_MAX, 1);
        send_elem(0, 0, 0, 32'sh0000_0100, 0);
        send_elem(0, 0, 1, 32'sh7000_0000, 1);
        write_size(4'd2);
        send_elem(0, 0, 0, '0, 0);
        send_elem(1, 0, 0, '0, 0);
        send_elem(0, 1, 0, 32'sh0001_0000, 0);
        send_elem(1, 1, 0, 32'sh0002_0000, 0);
        send_elem(0, 0, 1, 32'sh0003_0000, 0);
        send_elem(1, 0, 1, 32'sh0001_0000, 1);
        send_elem(0, 0, 0, 32'sh0001_0000, 0);
        send_elem(1, 0, 0, -32'sh0004_0000, 1);
        send_elem(1, 3, 1, 32'sh0000_8000, 1);
        write_size(4'd0);
        send_elem(0, 0, 0, -32'sh0002_0000, 1);
        write_size(4'd15);
        send_elem(7, 7, 0, 32'sh0005_0000, 1);
        write_size(4'd8);
        send_elem(3, 0, 1, -32'sh0001_0000, 1);

        while (items_sent < 300)
        begin
            cfg_val = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0) cfg_val = $urandom_range(1, 4);
            write_size(cfg_val[3:0]);
            n = cfg_val;
            if (n < 1) n = 1;
            if (n > lups_pkg::MAX_DIM) n = lups_pkg::MAX_DIM;
            if (!hold_used && items_sent > 150)
            begin
                long_hold = 1;
                hold_used = 1;
            end
            if ($urandom_range(0, 5) == 0)
                send_elem(lups_pkg::idx_t'($urandom), lups_pkg::idx_t'($urandom),
                          1'($urandom_range(0, 1)), $urandom, 1);
            else
                load_set(n, $urandom_range(0, 4) != 0, $urandom_range(0, 2));
        end

        load.valid <= 0;
        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
